FILE: rtl/sleep_wakeup_timer_queue_macros.svh
// Assertion macros for the sleep wakeup timer queue.
// Used by the top level; expects signals clk and rst in the calling scope.
`ifndef SLEEP_WAKEUP_TIMER_QUEUE_MACROS_SVH
`define SLEEP_WAKEUP_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define SWTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SWTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWTQ_ASSERT(lbl, prop, msg)
`define SWTQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/swtq_pkg.sv
// Shared types and constants for the sleep wakeup timer queue.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swtq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic [31:0] wtime;
    logic [3:0]  id;
    logic        blk;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

  typedef struct packed {
    logic keep;
    logic found;
  } cell_chain_t;

endpackage

`default_nettype wire

FILE: rtl/swtq_cell.sv
// One slot of the sorted sleeper chain: holds an entry, shifts with its neighbors.
// Depends on swtq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swtq_cell import swtq_pkg::*; (
  input  logic        clk,
  input  cell_cmd_t   cmd,
  input  logic        occ,
  input  logic [31:0] tick,
  input  entry_t      prev_ent,
  input  entry_t      next_ent,
  input  cell_chain_t chain_in,
  output cell_chain_t chain_out,
  output entry_t      ent,
  output logic        due
);

  entry_t ent_next;
  logic   le;
  logic   match;

  assign le              = occ && (ent.wtime <= cmd.ent.wtime);
  assign match           = occ && (ent.id == cmd.ent.id);
  assign chain_out.keep  = le;
  assign chain_out.found = chain_in.found | match;
  assign due             = occ && (ent.wtime <= tick);

  always_comb begin
    unique case (cmd.op)
      CELL_HOLD:   ent_next = ent;
      CELL_INSERT: begin
        if (le) begin
          ent_next = ent;
        end else if (chain_in.keep) begin
          ent_next = cmd.ent;
        end else begin
          ent_next = prev_ent;
        end
      end
      CELL_REMOVE: ent_next = chain_out.found ? next_ent : ent;
      CELL_POP:    ent_next = next_ent;
      default:     ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

FILE: rtl/sleep_wakeup_timer_queue.sv
// Sorted sleep queue with a 32-bit wrapping tick counter, built as a chain of
// MAX_SLEEPERS cells kept in wakeup order. An insert, remove or no-op transaction
// passes from acceptance through applying it to the chain and evaluating the head
// to the emit state, which loads its result into the output register once that is
// free. A tick gives one result per cycle while the output register is free, since
// the chain pops one head entry per cycle; at most 16 woken entries are emitted per tick. The next
// transaction is accepted once the last result has been loaded into the output
// register. No clearing pass follows reset.
// Depends on swtq_pkg, swtq_cell and sleep_wakeup_timer_queue_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sleep_wakeup_timer_queue_macros.svh"

module sleep_wakeup_timer_queue import swtq_pkg::*; #(
  parameter int MAX_SLEEPERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // thread_id[3:0], wakeup_time[35:4], is_blocked[36], tick_increment[52:37]
  input  logic [55:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // woken_id[3:0], timed_out[4], earliest_wakeup[36:5], list_empty[37],
  // full_error[38], tick_now[70:39]
  output logic [71:0] m_tdata,
  // woken_valid[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  localparam int N     = MAX_SLEEPERS;
  localparam int CNT_W = $clog2(N + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_APPLY, ST_EVAL, ST_EMIT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [31:0]      tick;
  logic [RES_W-1:0] popped;
  func_t            op_func;
  entry_t           op_ent;
  logic [15:0]      op_inc;
  logic             ferr;
  logic [31:0]      stat_earliest;
  logic             stat_empty;

  logic             out_valid;
  logic             out_wv;
  logic [3:0]       out_id;
  logic             out_tmo;
  logic             out_last;
  logic [31:0]      out_earliest;
  logic             out_empty;
  logic             out_ferr;
  logic [31:0]      out_tick;

  cell_cmd_t        cmd;
  entry_t           ents      [N];
  entry_t           prev_ents [N];
  entry_t           next_ents [N];
  cell_chain_t      chains    [N+1];
  logic [N-1:0]     occ;
  logic [N-1:0]     due_raw;
  logic [N-1:0]     due;
  logic [N-1:0]     bnd;
  logic [31:0]      head_sel;
  logic             cap_hit;
  logic [31:0]      cap_time;
  logic [31:0]      earliest_c;
  logic             empty_c;
  logic             slot_free;
  logic             last_c;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !out_valid || m_tready;
  assign chains[0] = '{keep: 1'b1, found: 1'b0};

  always_comb begin
    cmd.ent = op_ent;
    cmd.op  = CELL_HOLD;
    if (state == ST_APPLY) begin
      if (op_func == FUNC_INSERT && count < CNT_W'(N)) begin
        cmd.op = CELL_INSERT;
      end else if (op_func == FUNC_REMOVE) begin
        cmd.op = CELL_REMOVE;
      end
    end else if (state == ST_EMIT && slot_free && due[0]) begin
      cmd.op = CELL_POP;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_ents[i] = ents[i];
      assign bnd[i]       = occ[i] & ~due[i];
    end else begin : g_rest
      assign prev_ents[i] = ents[i-1];
      assign bnd[i]       = occ[i] & ~due[i] & due[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_ents[i] = ents[i];
    end else begin : g_inner
      assign next_ents[i] = ents[i+1];
    end
    assign occ[i] = CNT_W'(i) < count;
    assign due[i] = due_raw[i] & (op_func == FUNC_TICK);

    swtq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .tick      (tick),
      .prev_ent  (prev_ents[i]),
      .next_ent  (next_ents[i]),
      .chain_in  (chains[i]),
      .chain_out (chains[i+1]),
      .ent       (ents[i]),
      .due       (due_raw[i])
    );
  end

  if (N > MAX_RESULTS) begin : g_cap
    assign cap_hit  = due[MAX_RESULTS];
    assign cap_time = ents[MAX_RESULTS].wtime;
  end else begin : g_nocap
    assign cap_hit  = 1'b0;
    assign cap_time = '0;
  end

  always_comb begin
    head_sel = '0;
    for (int i = 0; i < N; i++) begin
      head_sel = head_sel | (bnd[i] ? ents[i].wtime : 32'd0);
    end
  end

  assign earliest_c = cap_hit ? cap_time : head_sel;
  assign empty_c    = cap_hit ? 1'b0 : ~(|bnd);
  assign last_c     = (popped == RES_W'(MAX_RESULTS - 1)) || !due[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      tick      <= '0;
      popped    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_func      <= func_t'(s_tuser);
            op_ent.id    <= s_tdata[3:0];
            op_ent.wtime <= s_tdata[35:4];
            op_ent.blk   <= s_tdata[36];
            op_inc       <= s_tdata[52:37];
            state        <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          ferr   <= (op_func == FUNC_INSERT) && (count == CNT_W'(N));
          popped <= '0;
          unique case (op_func)
            FUNC_INSERT: begin
              if (count != CNT_W'(N)) begin
                count <= count + CNT_W'(1);
              end
            end
            FUNC_REMOVE: begin
              if (chains[N].found) begin
                count <= count - CNT_W'(1);
              end
            end
            FUNC_TICK: tick <= tick + 32'(op_inc);
            FUNC_NOP:  ;
            default:   ;
          endcase
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          stat_earliest <= earliest_c;
          stat_empty    <= empty_c;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            out_earliest <= stat_earliest;
            out_empty    <= stat_empty;
            out_ferr     <= ferr;
            out_tick     <= tick;
            if (due[0]) begin
              out_wv   <= 1'b1;
              out_id   <= ents[0].id;
              out_tmo  <= ents[0].blk;
              out_last <= last_c;
              count    <= count - CNT_W'(1);
              popped   <= popped + RES_W'(1);
              if (last_c) begin
                state <= ST_IDLE;
              end
            end else begin
              out_wv   <= 1'b0;
              out_id   <= '0;
              out_tmo  <= 1'b0;
              out_last <= 1'b1;
              state    <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_wv;
  assign m_tdata  = {1'b0, out_tick, out_ferr, out_empty, out_earliest, out_tmo, out_id};

  `SWTQ_ASSERT_NEXT(a_pop_count, state == ST_EMIT && slot_free && due[0], count == $past(count) - CNT_W'(1), "pop did not decrement count")
  `SWTQ_ASSERT_NEXT(a_full_hold, state == ST_APPLY && op_func == FUNC_INSERT && count == CNT_W'(N), count == CNT_W'(N) && ferr, "full insert changed the list")
  `SWTQ_ASSERT(a_empty_head, (out_valid && out_empty) |-> (out_earliest == 32'd0), "empty list reports a head time")
  `SWTQ_ASSERT(a_wake_noerr, (out_valid && out_wv) |-> !out_ferr, "woken result flagged full")

endmodule

`default_nettype wire
